// ===== hw/rtl/ict_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ict_pkg: shared types and constants for the interval clip table.
// Holds the field widths, the command codes and the word structs.
// ----------------------------------------------------------------------------
package ict_pkg;

    localparam int ENTRIES    = 64;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int FRAME_BITS = 24;
    localparam int ID_BITS    = 16;
    localparam int CMD_BITS   = 3;

    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_DELETE = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_MOVE   = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CHECK  = 3'd4;

    typedef logic [FRAME_BITS-1:0] t_frame;
    typedef logic [ID_BITS-1:0]    t_id;
    typedef logic [IDX_BITS-1:0]   t_idx;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        t_frame              frame_a;
        t_frame              frame_b;
        t_frame              length;
        t_id                 clip_id;
    } t_in_word;

    typedef struct packed {
        logic   found;
        t_id    hit_id;
        t_frame hit_start;
        logic   status;
    } t_out_word;

    // One stored entry as held in the table memory.
    typedef struct packed {
        t_frame start;
        t_frame length;
        t_id    id;
    } t_entry;

endpackage : ict_pkg
`default_nettype wire

// ===== hw/rtl/ict_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ict_in_if / ict_out_if: valid/ready channels of the interval clip table.
// Each carries one word per handshake.
// ----------------------------------------------------------------------------
interface ict_in_if;
    logic              valid;
    logic              ready;
    ict_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : ict_in_if

interface ict_out_if;
    logic               valid;
    logic               ready;
    ict_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface : ict_out_if
`default_nettype wire

// ===== hw/rtl/interval_clip_table_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// interval_clip_table_unit: table of timeline intervals keyed by start frame.
//
// A command word enters on i_cmd (valid/ready) and exactly one result word
// leaves on o_res. Commands: lookup, add, delete, move, overlap check.
// Entries live in a synchronous memory of ENTRIES rows with one read and one
// write port; a valid bit per row sits in flip-flops. Each pass sweeps the
// memory one row a cycle through a registered read port, followed by an
// evaluation state. Lookup and delete use one pass, add one pass and a write
// state, move two passes (delete, then add) and a write state, check up to
// three passes (lookup at both span ends, then the nearest following start).
// One command is worked on at a time. Reset clears all valid bits together;
// no clearing pass is needed. The result sits in an output register; a
// stalled receiver holds it, and the next command can be taken in the cycle
// after the result has been accepted.
// ----------------------------------------------------------------------------
module interval_clip_table_unit (
    input  wire   i_clk,
    input  wire   i_rst_n,
    ict_in_if.sink    i_cmd,
    ict_out_if.source o_res
);
    import ict_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_WRITE = 3'd2;
    localparam logic [2:0] ST_OUT   = 3'd3;
    localparam logic [2:0] ST_EVAL  = 3'd4;

    // Pass kinds of the sweep.
    localparam logic [1:0] PS_MAIN = 2'd0;  // lookup a / find start / check a
    localparam logic [1:0] PS_B    = 2'd1;  // check lookup at b / move add
    localparam logic [1:0] PS_NEXT = 2'd2;  // check nearest following start

    logic [2:0]     r_state;
    logic [1:0]     r_pass;
    t_in_word       r_req;
    logic [IDX_BITS:0] r_addr;    // row being issued, ENTRIES when done
    logic           r_rd_vld;
    t_idx           r_rd_idx;
    logic [ENTRIES-1:0] r_valid;
    t_entry         r_mem [ENTRIES];
    t_entry         r_rd;

    // Sweep results.
    logic   r_best_vld;           // best start <= key so far (nearest following start in the next-start pass)
    t_entry r_best;
    logic   r_match_vld;          // row with start equal to key
    t_idx   r_match_idx;
    logic   r_free_vld;           // lowest free row
    t_idx   r_free_idx;
    t_out_word r_out;
    logic   r_out_vld;

    t_frame w_key;
    logic   w_last;
    logic   w_row_ok;
    logic   w_hit;
    logic   w_conf;
    t_frame w_diff;
    logic   w_drop;

    t_out_word  n_out;
    logic [1:0] n_pass;
    logic [2:0] n_state;

    assign w_key    = (r_pass == PS_B) ? r_req.frame_b : r_req.frame_a;
    assign w_last   = r_rd_vld && (r_rd_idx == t_idx'(ENTRIES - 1));
    assign w_row_ok = r_rd_vld && r_valid[r_rd_idx];
    assign w_diff   = w_key - r_best.start;
    assign w_hit    = r_best_vld && (w_diff < r_best.length);
    assign w_conf   = w_hit && (r_best.id != r_req.clip_id);

    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_out_vld;
    assign o_res.data  = r_out;

    // Memory read port, one row per cycle while sweeping, and the write port used in the write state.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[r_addr[IDX_BITS-1:0]];
        if (r_state == ST_WRITE && (r_match_vld || r_free_vld)) begin
            r_mem[r_match_vld ? r_match_idx : r_free_idx] <=
                '{start: (r_req.cmd == CMD_MOVE) ? r_req.frame_b : r_req.frame_a,
                  length: r_req.length, id: r_req.clip_id};
        end
    end

    // End-of-pass decision: the result word, the next pass to run or the write, and any row to drop.
    always_comb begin
        n_out   = '0;
        n_pass  = r_pass;
        n_state = ST_OUT;
        w_drop  = 1'b0;
        case (r_req.cmd)
            CMD_LOOKUP: begin
                if (w_hit) begin
                    n_out.found     = 1'b1;
                    n_out.hit_id    = r_best.id;
                    n_out.hit_start = r_best.start;
                end
            end
            CMD_ADD: begin
                n_state = ST_WRITE;
            end
            CMD_DELETE: begin
                w_drop = r_match_vld;
            end
            CMD_MOVE: begin
                if (r_pass == PS_MAIN) begin
                    w_drop  = r_match_vld;
                    n_pass  = PS_B;
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_WRITE;
                end
            end
            CMD_CHECK: begin
                if (r_pass == PS_NEXT) begin
                    if (r_best_vld && r_best.start <= r_req.frame_b) begin
                        n_out.found     = 1'b1;
                        n_out.hit_id    = r_best.id;
                        n_out.hit_start = r_best.start;
                    end
                end else if (w_conf) begin
                    n_out.found     = 1'b1;
                    n_out.hit_id    = r_best.id;
                    n_out.hit_start = r_best.start;
                end else begin
                    n_pass  = (r_pass == PS_MAIN) ? PS_B : PS_NEXT;
                    n_state = ST_SCAN;
                end
            end
            default: begin
            end
        endcase
    end

    // Control, sweep accumulation and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        r_req       <= i_cmd.data;
                        r_pass      <= PS_MAIN;
                        r_addr      <= '0;
                        r_rd_vld    <= 1'b0;
                        r_best_vld  <= 1'b0;
                        r_match_vld <= 1'b0;
                        r_free_vld  <= 1'b0;
                        r_state     <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // Issue the next row address and mark the read return.
                    r_rd_vld <= (r_addr < (IDX_BITS+1)'(ENTRIES));
                    r_rd_idx <= r_addr[IDX_BITS-1:0];
                    if (r_addr < (IDX_BITS+1)'(ENTRIES)) begin
                        r_addr <= r_addr + (IDX_BITS+1)'(1);
                    end
                    if (r_rd_vld) begin
                        if (!r_valid[r_rd_idx] && !r_free_vld) begin
                            r_free_vld <= 1'b1;
                            r_free_idx <= r_rd_idx;
                        end
                        if (w_row_ok && r_rd.start == w_key && !r_match_vld) begin
                            r_match_vld <= 1'b1;
                            r_match_idx <= r_rd_idx;
                        end
                        if (r_pass == PS_NEXT) begin
                            if (w_row_ok && r_rd.id != r_req.clip_id &&
                                r_rd.start > r_req.frame_a &&
                                (!r_best_vld || r_rd.start < r_best.start)) begin
                                r_best_vld <= 1'b1;
                                r_best     <= r_rd;
                            end
                        end else if (w_row_ok && r_rd.start <= w_key &&
                                     (!r_best_vld || r_rd.start > r_best.start)) begin
                            r_best_vld <= 1'b1;
                            r_best     <= r_rd;
                        end
                    end
                    if (w_last) begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    // The last row is folded in; act on the complete sweep.
                    r_out   <= n_out;
                    r_pass  <= n_pass;
                    r_state <= n_state;
                    if (n_state == ST_SCAN) begin
                        r_addr      <= '0;
                        r_best_vld  <= 1'b0;
                        r_match_vld <= 1'b0;
                        r_free_vld  <= 1'b0;
                    end
                    if (w_drop) begin
                        r_valid[r_match_idx] <= 1'b0;
                    end
                end
                ST_WRITE: begin
                    // Overwrite by start, else take the lowest free row.
                    r_out.status <= !(r_match_vld || r_free_vld);
                    if (r_match_vld) begin
                        r_valid[r_match_idx] <= 1'b1;
                    end else if (r_free_vld) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    // Present the result word and wait for it to be taken.
                    if (!r_out_vld) begin
                        r_out_vld <= 1'b1;
                    end else if (o_res.ready) begin
                        r_out_vld <= 1'b0;
                        r_state   <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // A result word is only shown in the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_state == ST_OUT))
        else $error("result valid outside output state");
    // No command is taken while a result is pending.
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !i_cmd.ready)
        else $error("command accepted with result pending");
    // Status is only raised by an add or a move.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.status) |->
            (r_req.cmd == CMD_ADD || r_req.cmd == CMD_MOVE))
        else $error("full status on wrong command");

endmodule : interval_clip_table_unit
`default_nettype wire
